>>> hw/rtl/plnc_pkg.sv
package plnc_pkg;

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_BOOT_NODE_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD = 1'd1;

  localparam logic [15:0] BOOT_NODE_ID_RST = 16'd0;
  localparam logic [15:0] BLINK_PERIOD_RST = 16'd3000;

  localparam logic [7:0] FRAME_ID_HIGH = 8'h6B;
  localparam logic [7:0] FRAME_LOW_MASK = 8'hE0;
  localparam logic [7:0] FRAME_LOW_MATCH = 8'hC0;
  localparam logic [15:0] ASCII_ZERO = 16'h0030;

  localparam logic [3:0] KEY_NONE = 4'h0;
  localparam logic [3:0] KEY_INC = 4'h1;
  localparam logic [3:0] KEY_DEC = 4'h2;
  localparam logic [3:0] KEY_ACK = 4'h4;
  localparam logic [3:0] KEY_EDIT = 4'h8;

  localparam logic [1:0] DISP_DARK = 2'd0;
  localparam logic [1:0] DISP_NODE = 2'd1;
  localparam logic [1:0] DISP_COUNT = 2'd2;

  typedef enum logic [3:0] {
    MODE_BLANK = 4'b0001,
    MODE_EDIT  = 4'b0010,
    MODE_COUNT = 4'b0100,
    MODE_ACK   = 4'b1000
  } mode_t;

  // four ASCII bytes, MSB first, weighted 1000/100/10/1, all mod 2^16
  function automatic logic [15:0] decode_digits(input logic [31:0] word);
    logic [15:0] d3;
    logic [15:0] d2;
    logic [15:0] d1;
    logic [15:0] d0;
    d3 = {8'd0, word[31:24]} - ASCII_ZERO;
    d2 = {8'd0, word[23:16]} - ASCII_ZERO;
    d1 = {8'd0, word[15:8]} - ASCII_ZERO;
    d0 = {8'd0, word[7:0]} - ASCII_ZERO;
    return 16'(d3 * 16'd1000) + 16'(d2 * 16'd100) + 16'(d1 * 16'd10) + d0;
  endfunction

endpackage

>>> hw/rtl/pick_light_node_controller.sv
// Pick-light node controller. Each transaction on the in_ channel is one control-loop pass
// and yields exactly one transaction on the out_ channel. A pass is captured in an input
// register, evaluated there against the node state, and moves into the output register
// once the output side can take it. One pass can be accepted every cycle while the
// output side keeps up. in_stall follows out_stall when both registers are full.
// Configuration writes are always ready; a write to boot_node_id also reloads the node id.
module pick_light_node_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [3:0]                    in_key_lines,
  input  logic                          in_frame_valid,
  input  logic [7:0]                    in_frame_id_high,
  input  logic [7:0]                    in_frame_id_low,
  input  logic [31:0]                   in_node_digits,
  input  logic [31:0]                   in_count_digits,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_display_mode,
  output logic [15:0]                   out_display_value,
  output logic                          out_led_on,
  output logic                          out_ack_req,
  output logic                          out_save_node_id,
  output logic [15:0]                   out_node_id_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [plnc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);

  // configuration
  logic [15:0] blink_period_r;

  // node state
  plnc_pkg::mode_t mode_r, mode_nxt;
  logic [15:0] node_id_r, node_id_nxt;
  logic [15:0] pick_count_r, pick_count_nxt;
  logic [15:0] blink_ticks_r, blink_ticks_nxt;
  logic        key_armed_r, key_armed_nxt;
  logic        led_r, led_nxt;

  // input register
  logic        s1_valid_r;
  logic [3:0]  s1_keys_r;
  logic        s1_fv_r;
  logic [7:0]  s1_idh_r;
  logic [7:0]  s1_idl_r;
  logic [31:0] s1_node_r;
  logic [31:0] s1_count_r;

  // output register
  logic        out_valid_r;
  logic [1:0]  disp_mode_r, disp_mode_nxt;
  logic [15:0] disp_value_r, disp_value_nxt;
  logic        ack_r, ack_nxt;
  logic        save_r, save_nxt;
  logic        led_out_r;
  logic [15:0] node_out_r;

  logic        advance;
  logic        in_take;
  logic        cfg_take;
  logic [3:0]  key;
  logic        frame_hit;
  plnc_pkg::mode_t mode_f;
  logic [15:0] pick_f;
  logic [15:0] ticks_inc;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_take = cfg_valid && cfg_ready;

  always_comb begin
    key = (s1_keys_r != plnc_pkg::KEY_NONE && key_armed_r) ? s1_keys_r : plnc_pkg::KEY_NONE;
    key_armed_nxt = (s1_keys_r == plnc_pkg::KEY_NONE);

    frame_hit = s1_fv_r && (s1_idh_r == plnc_pkg::FRAME_ID_HIGH) &&
                ((s1_idl_r & plnc_pkg::FRAME_LOW_MASK) == plnc_pkg::FRAME_LOW_MATCH) &&
                (plnc_pkg::decode_digits(s1_node_r) == node_id_r);
    mode_f = frame_hit ? plnc_pkg::MODE_COUNT : mode_r;
    pick_f = frame_hit ? plnc_pkg::decode_digits(s1_count_r) : pick_count_r;
    ticks_inc = blink_ticks_r + 16'd1;

    mode_nxt        = mode_f;
    node_id_nxt     = node_id_r;
    pick_count_nxt  = pick_f;
    blink_ticks_nxt = blink_ticks_r;
    led_nxt         = led_r;
    disp_mode_nxt   = plnc_pkg::DISP_DARK;
    disp_value_nxt  = 16'd0;
    ack_nxt         = 1'b0;
    save_nxt        = 1'b0;

    unique case (mode_f)
      plnc_pkg::MODE_BLANK: begin
        led_nxt = 1'b0;
        if (key == plnc_pkg::KEY_EDIT) begin
          mode_nxt = plnc_pkg::MODE_EDIT;
        end
      end
      plnc_pkg::MODE_EDIT: begin
        disp_mode_nxt  = plnc_pkg::DISP_NODE;
        disp_value_nxt = node_id_r;
        if (key == plnc_pkg::KEY_INC) begin
          node_id_nxt = node_id_r + 16'd1;
        end
        if (key == plnc_pkg::KEY_DEC && node_id_r != 16'd0) begin
          node_id_nxt = node_id_r - 16'd1;
        end
        if (key == plnc_pkg::KEY_ACK) begin
          save_nxt = 1'b1;
          mode_nxt = plnc_pkg::MODE_BLANK;
        end
      end
      plnc_pkg::MODE_COUNT: begin
        disp_mode_nxt   = plnc_pkg::DISP_COUNT;
        disp_value_nxt  = pick_f;
        blink_ticks_nxt = ticks_inc;
        if (ticks_inc > blink_period_r) begin
          blink_ticks_nxt = 16'd0;
          led_nxt = !led_r;
          if (pick_f != 16'd0) begin
            pick_count_nxt = pick_f - 16'd1;
          end else begin
            mode_nxt = plnc_pkg::MODE_ACK;
          end
        end
      end
      default: begin
        ack_nxt  = 1'b1;
        led_nxt  = 1'b0;
        mode_nxt = plnc_pkg::MODE_BLANK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_period_r <= plnc_pkg::BLINK_PERIOD_RST;
      mode_r         <= plnc_pkg::MODE_BLANK;
      node_id_r      <= plnc_pkg::BOOT_NODE_ID_RST;
      pick_count_r   <= 16'd0;
      blink_ticks_r  <= 16'd0;
      key_armed_r    <= 1'b1;
      led_r          <= 1'b0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_take && cfg_index == plnc_pkg::REG_BLINK_PERIOD) begin
        blink_period_r <= cfg_data;
      end
      if (cfg_take && cfg_index == plnc_pkg::REG_BOOT_NODE_ID) begin
        node_id_r <= cfg_data;
      end else if (advance) begin
        node_id_r <= node_id_nxt;
      end
      if (advance) begin
        mode_r        <= mode_nxt;
        pick_count_r  <= pick_count_nxt;
        blink_ticks_r <= blink_ticks_nxt;
        key_armed_r   <= key_armed_nxt;
        led_r         <= led_nxt;
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_keys_r  <= in_key_lines;
      s1_fv_r    <= in_frame_valid;
      s1_idh_r   <= in_frame_id_high;
      s1_idl_r   <= in_frame_id_low;
      s1_node_r  <= in_node_digits;
      s1_count_r <= in_count_digits;
    end
    if (advance) begin
      disp_mode_r  <= disp_mode_nxt;
      disp_value_r <= disp_value_nxt;
      ack_r        <= ack_nxt;
      save_r       <= save_nxt;
      led_out_r    <= led_nxt;
      node_out_r   <= node_id_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_display_mode  = disp_mode_r;
  assign out_display_value = disp_value_r;
  assign out_led_on        = led_out_r;
  assign out_ack_req       = ack_r;
  assign out_save_node_id  = save_r;
  assign out_node_id_out   = node_out_r;

endmodule

>>> hw/rtl/plnc_checker.sv
module plnc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    out_display_mode,
  input logic [15:0]                   out_display_value,
  input logic                          out_led_on,
  input logic                          out_ack_req,
  input logic                          out_save_node_id,
  input logic [15:0]                   out_node_id_out
);

  // stalled result stays valid and keeps its display value, node id and acknowledge
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_display_value) &&
    $stable(out_node_id_out) && $stable(out_ack_req))
    else $error("stalled result changed");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_dark_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_display_mode == plnc_pkg::DISP_DARK |-> out_display_value == 16'd0)
    else $error("dark display with nonzero value");

  a_ack_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ack_req |->
      !out_led_on && !out_save_node_id && out_display_mode == plnc_pkg::DISP_DARK)
    else $error("acknowledge pass not dark");

  a_save_edit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_save_node_id |-> out_display_mode == plnc_pkg::DISP_NODE &&
      out_node_id_out == out_display_value)
    else $error("save outside node-id edit");

endmodule

bind pick_light_node_controller plnc_checker u_plnc_checker (.*);

>>> dv/pick_light_node_controller_test.sv
module pick_light_node_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD_CYCLES = 150;

  typedef struct packed {
    logic [3:0]  key_lines;
    logic        frame_valid;
    logic [7:0]  id_high;
    logic [7:0]  id_low;
    logic [31:0] node_digits;
    logic [31:0] count_digits;
  } pass_t;

  typedef struct packed {
    logic [1:0]  display_mode;
    logic [15:0] display_value;
    logic        led_on;
    logic        ack_req;
    logic        save_node_id;
    logic [15:0] node_id_out;
  } light_result_t;

  class pick_scoreboard;
    logic [15:0] boot_id;
    logic [15:0] period;
    plnc_pkg::mode_t mode;
    logic [15:0] node_id;
    logic [15:0] pick_count;
    logic [15:0] ticks;
    bit armed;
    bit led;
    light_result_t pending[$];
    int errors;

    function new();
      boot_id = plnc_pkg::BOOT_NODE_ID_RST;
      period = plnc_pkg::BLINK_PERIOD_RST;
      mode = plnc_pkg::MODE_BLANK;
      node_id = plnc_pkg::BOOT_NODE_ID_RST;
      pick_count = '0;
      ticks = '0;
      armed = 1'b1;
      led = 1'b0;
      errors = 0;
    endfunction

    function logic [15:0] digit_word_value(logic [31:0] w);
      logic [15:0] acc;
      acc = '0;
      for (int i = 3; i >= 0; i--) begin
        acc = acc * 16'd10 + (16'(w[i*8 +: 8]) - plnc_pkg::ASCII_ZERO);
      end
      return acc;
    endfunction

    function void note_config(logic [plnc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
      if (idx == plnc_pkg::REG_BOOT_NODE_ID) begin
        boot_id = data;
        node_id = data;
      end else begin
        period = data;
      end
    endfunction

    function void note_pass(pass_t p);
      logic [3:0] key;
      light_result_t r;
      key = plnc_pkg::KEY_NONE;
      r = '0;
      if (p.key_lines != plnc_pkg::KEY_NONE && armed) begin
        armed = 1'b0;
        key = p.key_lines;
      end else if (p.key_lines == plnc_pkg::KEY_NONE) begin
        armed = 1'b1;
      end
      if (p.frame_valid && p.id_high == plnc_pkg::FRAME_ID_HIGH &&
          (p.id_low & plnc_pkg::FRAME_LOW_MASK) == plnc_pkg::FRAME_LOW_MATCH &&
          digit_word_value(p.node_digits) == node_id) begin
        pick_count = digit_word_value(p.count_digits);
        mode = plnc_pkg::MODE_COUNT;
      end
      case (mode)
        plnc_pkg::MODE_BLANK: begin
          led = 1'b0;
          if (key == plnc_pkg::KEY_EDIT) mode = plnc_pkg::MODE_EDIT;
        end
        plnc_pkg::MODE_EDIT: begin
          r.display_mode = plnc_pkg::DISP_NODE;
          r.display_value = node_id;
          if (key == plnc_pkg::KEY_INC) node_id = node_id + 16'd1;
          if (key == plnc_pkg::KEY_DEC && node_id != 16'd0) node_id = node_id - 16'd1;
          if (key == plnc_pkg::KEY_ACK) begin
            r.save_node_id = 1'b1;
            mode = plnc_pkg::MODE_BLANK;
          end
        end
        plnc_pkg::MODE_COUNT: begin
          r.display_mode = plnc_pkg::DISP_COUNT;
          r.display_value = pick_count;
          ticks = ticks + 16'd1;
          if (ticks > period) begin
            ticks = '0;
            led = ~led;
            if (pick_count != 16'd0) pick_count = pick_count - 16'd1;
            else mode = plnc_pkg::MODE_ACK;
          end
        end
        default: begin
          r.ack_req = 1'b1;
          led = 1'b0;
          mode = plnc_pkg::MODE_BLANK;
        end
      endcase
      r.led_on = led;
      r.node_id_out = node_id;
      pending.push_back(r);
    endfunction

    function void check_result(light_result_t got);
      light_result_t want;
      if (pending.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.display_mode !== want.display_mode) begin
        $error("display_mode: expected %0d, actual %0d", want.display_mode, got.display_mode);
        errors++;
      end
      if (got.display_value !== want.display_value) begin
        $error("display_value: expected %0d, actual %0d", want.display_value,
               got.display_value);
        errors++;
      end
      if (got.led_on !== want.led_on) begin
        $error("led_on: expected %0d, actual %0d", want.led_on, got.led_on);
        errors++;
      end
      if (got.ack_req !== want.ack_req) begin
        $error("ack_req: expected %0d, actual %0d", want.ack_req, got.ack_req);
        errors++;
      end
      if (got.save_node_id !== want.save_node_id) begin
        $error("save_node_id: expected %0d, actual %0d", want.save_node_id, got.save_node_id);
        errors++;
      end
      if (got.node_id_out !== want.node_id_out) begin
        $error("node_id_out: expected %0d, actual %0d", want.node_id_out, got.node_id_out);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [3:0]           in_key_lines;
  logic                 in_frame_valid;
  logic [7:0]           in_frame_id_high;
  logic [7:0]           in_frame_id_low;
  logic [31:0]          in_node_digits;
  logic [31:0]          in_count_digits;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_display_mode;
  logic [15:0]          out_display_value;
  logic                 out_led_on;
  logic                 out_ack_req;
  logic                 out_save_node_id;
  logic [15:0]          out_node_id_out;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [plnc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  pick_scoreboard sb;
  bit long_hold_req = 1'b0;
  int quiet_cycles = 0;

  pick_light_node_controller u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_key_lines      (in_key_lines),
    .in_frame_valid    (in_frame_valid),
    .in_frame_id_high  (in_frame_id_high),
    .in_frame_id_low   (in_frame_id_low),
    .in_node_digits    (in_node_digits),
    .in_count_digits   (in_count_digits),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_display_mode  (out_display_mode),
    .out_display_value (out_display_value),
    .out_led_on        (out_led_on),
    .out_ack_req       (out_ack_req),
    .out_save_node_id  (out_save_node_id),
    .out_node_id_out   (out_node_id_out),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // any 16-bit value, as ASCII-offset bytes; the top byte may exceed '9'
  function automatic logic [31:0] id_to_digits(int unsigned v);
    return {8'(48 + v / 1000), 8'(48 + (v / 100) % 10), 8'(48 + (v / 10) % 10),
            8'(48 + v % 10)};
  endfunction

  function automatic pass_t mk_pass(logic [3:0] keys, logic fv = 1'b0,
                                    logic [7:0] idh = '0, logic [7:0] idl = '0,
                                    logic [31:0] nd = '0, logic [31:0] cd = '0);
    pass_t p;
    p.key_lines = keys;
    p.frame_valid = fv;
    p.id_high = idh;
    p.id_low = idl;
    p.node_digits = nd;
    p.count_digits = cd;
    return p;
  endfunction

  function automatic pass_t random_pass(int match_pct);
    pass_t p;
    int pick;
    p.key_lines = 4'($urandom);
    p.frame_valid = 1'b0;
    p.id_high = 8'($urandom);
    p.id_low = 8'($urandom);
    p.node_digits = $urandom;
    p.count_digits = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      p.key_lines = plnc_pkg::KEY_NONE;
    end else if (pick < 90) begin
      case ($urandom_range(0, 3))
        0: p.key_lines = plnc_pkg::KEY_INC;
        1: p.key_lines = plnc_pkg::KEY_DEC;
        2: p.key_lines = plnc_pkg::KEY_ACK;
        default: p.key_lines = plnc_pkg::KEY_EDIT;
      endcase
    end
    pick = $urandom_range(0, 99);
    if (pick < match_pct) begin
      p.frame_valid = 1'b1;
      p.id_high = plnc_pkg::FRAME_ID_HIGH;
      p.id_low = plnc_pkg::FRAME_LOW_MATCH | (p.id_low & ~plnc_pkg::FRAME_LOW_MASK);
      if ($urandom_range(0, 9) != 0) p.node_digits = id_to_digits(sb.node_id);
      case ($urandom_range(0, 9))
        0: p.count_digits = $urandom;
        1: p.count_digits = id_to_digits($urandom_range(0, 65535));
        default: p.count_digits = id_to_digits($urandom_range(0, 4));
      endcase
    end else if (pick < match_pct + 10) begin
      // one identifier bit off, otherwise addressed to us
      p.frame_valid = 1'b1;
      p.node_digits = id_to_digits(sb.node_id);
      p.count_digits = id_to_digits($urandom_range(0, 4));
      p.id_high = plnc_pkg::FRAME_ID_HIGH;
      p.id_low = plnc_pkg::FRAME_LOW_MATCH | (p.id_low & ~plnc_pkg::FRAME_LOW_MASK);
      if ($urandom_range(0, 1)) begin
        p.id_high = plnc_pkg::FRAME_ID_HIGH ^ (8'd1 << $urandom_range(0, 7));
      end else begin
        p.id_low = p.id_low ^ (8'h20 << $urandom_range(0, 2));
      end
    end else if (pick < match_pct + 15) begin
      p.frame_valid = 1'b1;
    end
    return p;
  endfunction

  task automatic send_pass(input pass_t p, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key_lines <= p.key_lines;
    in_frame_valid <= p.frame_valid;
    in_frame_id_high <= p.id_high;
    in_frame_id_low <= p.id_low;
    in_node_digits <= p.node_digits;
    in_count_digits <= p.count_digits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pass(p);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [plnc_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int n_items, input int match_pct, input bit with_hold,
                            input bit with_pause);
    int burst_left;
    int gap;
    burst_left = 0;
    for (int i = 0; i < n_items; i++) begin
      gap = 0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
      end
      burst_left--;
      if (with_hold && i == n_items / 3) long_hold_req = 1'b1;
      if (with_pause && i == n_items / 2) drain_results();
      send_pass(random_pass(match_pct), gap);
    end
  endtask

  // receiver back-pressure
  initial begin
    int style;
    int len;
    style = 0;
    len = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if (len == 0) begin
          style = $urandom_range(0, 3);
          len = $urandom_range(10, 80);
        end
        len--;
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({out_display_mode, out_display_value, out_led_on, out_ack_req,
                       out_save_node_id, out_node_id_out});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    logic [15:0] boot;
    logic [15:0] period;
    int n;
    int pct;
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_key_lines <= '0;
    in_frame_valid <= 1'b0;
    in_frame_id_high <= '0;
    in_frame_id_low <= '0;
    in_node_digits <= '0;
    in_count_digits <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // edit mode at reset values: floor at zero, held key, combined keys, save
    send_pass(mk_pass(plnc_pkg::KEY_NONE), 0);
    send_pass(mk_pass(plnc_pkg::KEY_EDIT), 0);
    send_pass(mk_pass(plnc_pkg::KEY_NONE), 0);
    send_pass(mk_pass(plnc_pkg::KEY_DEC), 0);
    send_pass(mk_pass(plnc_pkg::KEY_NONE), 0);
    send_pass(mk_pass(plnc_pkg::KEY_INC), 0);
    send_pass(mk_pass(plnc_pkg::KEY_INC), 0);
    send_pass(mk_pass(plnc_pkg::KEY_NONE), 0);
    send_pass(mk_pass(plnc_pkg::KEY_INC | plnc_pkg::KEY_DEC), 0);
    send_pass(mk_pass(plnc_pkg::KEY_NONE), 0);
    send_pass(mk_pass(plnc_pkg::KEY_ACK), 0);
    send_pass(mk_pass(plnc_pkg::KEY_NONE), 0);
    drain_results();

    // id wrap, frame while editing, reload while counting, id misses, acknowledge
    write_reg(plnc_pkg::REG_BOOT_NODE_ID, 16'hFFFF);
    write_reg(plnc_pkg::REG_BLINK_PERIOD, 16'd0);
    send_pass(mk_pass(plnc_pkg::KEY_EDIT), 0);
    send_pass(mk_pass(plnc_pkg::KEY_NONE), 0);
    send_pass(mk_pass(plnc_pkg::KEY_INC), 0);
    send_pass(mk_pass(plnc_pkg::KEY_NONE, 1'b1, plnc_pkg::FRAME_ID_HIGH,
                      plnc_pkg::FRAME_LOW_MATCH, id_to_digits(0), 32'h2F2F2F2F), 0);
    send_pass(mk_pass(4'hF, 1'b1, plnc_pkg::FRAME_ID_HIGH, 8'hDF, id_to_digits(0),
                      id_to_digits(2)), 0);
    send_pass(mk_pass(plnc_pkg::KEY_NONE, 1'b1, plnc_pkg::FRAME_ID_HIGH ^ 8'h01,
                      plnc_pkg::FRAME_LOW_MATCH, id_to_digits(0), id_to_digits(9)), 0);
    send_pass(mk_pass(plnc_pkg::KEY_ACK, 1'b1, plnc_pkg::FRAME_ID_HIGH, 8'hA0,
                      id_to_digits(0), id_to_digits(9)), 0);
    repeat (5) send_pass(mk_pass(plnc_pkg::KEY_NONE), 0);
    send_pass(mk_pass(plnc_pkg::KEY_NONE, 1'b0, plnc_pkg::FRAME_ID_HIGH,
                      plnc_pkg::FRAME_LOW_MATCH, id_to_digits(0), 32'hFFFFFFFF), 0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin boot = 16'hFFFF; period = 16'd0; n = 300; pct = 6; end
        1: begin boot = 16'($urandom); period = 16'd1; n = 300; pct = 5; end
        2: begin boot = 16'd1234; period = 16'd3; n = 350; pct = 4; end
        3: begin boot = 16'd0; period = 16'hFFFF; n = 200; pct = 2; end
        4: begin boot = 16'($urandom); period = 16'($urandom_range(0, 7)); n = 350; pct = 5; end
        default: begin boot = 16'd9999; period = 16'd2; n = 350; pct = 4; end
      endcase
      drain_results();
      write_reg(plnc_pkg::REG_BOOT_NODE_ID, boot);
      write_reg(plnc_pkg::REG_BLINK_PERIOD, period);
      run_random(n, pct, ph == 1, ph == 2);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
